### src/smn_pkg.sv
// Shared constants and word functions for the Simon 48/72 cipher engine.
package smn_pkg;

  localparam int unsigned WORD_W         = 24;
  localparam int unsigned KEY_WORDS      = 3;
  localparam int unsigned KEY_IDX_W      = 2;
  localparam int unsigned NUM_ROUNDS_DEF = 36;
  localparam int unsigned ZSEQ_LEN       = 62;

  localparam logic [ZSEQ_LEN-1:0] Z0_SEQ   = 62'h19C3522FB386A45F;
  localparam logic [WORD_W-1:0]   KEY_CONST = 24'hFFFFFC;

  localparam logic [KEY_IDX_W-1:0] KEY_LOW  = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_MID  = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_HIGH = 2'd2;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] v, input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int unsigned r);
    return (v >> r) | (v << (WORD_W - r));
  endfunction

  // Feistel mixing of one round, without key and y
  function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x);
    return (rol(x, 1) & rol(x, 8)) ^ rol(x, 2);
  endfunction

endpackage

### src/smn_key_sched.sv
// Key registers, round key expansion sequencer and round key memory.
module smn_key_sched import smn_pkg::*; #(
  parameter int unsigned NUM_ROUNDS = NUM_ROUNDS_DEF,
  parameter int unsigned ADDR_W     = $clog2(NUM_ROUNDS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output logic [WORD_W-1:0]    rd_data_o,
  output logic                 busy_o
);

  localparam logic [ADDR_W-1:0] LAST   = ADDR_W'(NUM_ROUNDS - 1);
  localparam logic [ADDR_W-1:0] NKEYS  = ADDR_W'(KEY_WORDS);

  logic [WORD_W-1:0] key_q [KEY_WORDS];
  logic [WORD_W-1:0] key_new [KEY_WORDS];
  logic [WORD_W-1:0] w0_q, w1_q, w2_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              busy_q;
  logic              key_wr;
  logic [ADDR_W-1:0] exp_i;
  logic [WORD_W-1:0] t3, new_w, wr_data;
  logic [WORD_W-1:0] mem [NUM_ROUNDS];
  logic [WORD_W-1:0] rd_q;

  always_comb begin
    key_wr = cfg_we_i && (cfg_idx_i == KEY_LOW || cfg_idx_i == KEY_MID ||
                          cfg_idx_i == KEY_HIGH);
    for (int k = 0; k < KEY_WORDS; k++) begin
      key_new[k] = (key_wr && cfg_idx_i == KEY_IDX_W'(k)) ? cfg_data_i : key_q[k];
    end
  end

  // k[i+3] = k[i] ^ c ^ z(i) ^ ror3(k[i+2]) ^ ror4(k[i+2])
  always_comb begin
    exp_i   = cnt_q - NKEYS;
    t3      = ror(w2_q, 3);
    new_w   = w0_q ^ t3 ^ ror(t3, 1) ^ KEY_CONST ^ {{(WORD_W-1){1'b0}}, Z0_SEQ[exp_i]};
    wr_data = (cnt_q < NKEYS) ? key_q[cnt_q[KEY_IDX_W-1:0]] : new_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_WORDS; k++) key_q[k] <= '0;
      w0_q   <= '0;
      w1_q   <= '0;
      w2_q   <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else if (key_wr) begin
      // any key write restarts the expansion from the first word
      for (int k = 0; k < KEY_WORDS; k++) key_q[k] <= key_new[k];
      w0_q   <= key_new[0];
      w1_q   <= key_new[1];
      w2_q   <= key_new[2];
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (cnt_q >= NKEYS) begin
        w0_q <= w1_q;
        w1_q <= w2_q;
        w2_q <= new_w;
      end
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !key_wr) begin
      mem[cnt_q] <= wr_data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

### src/simon48_72_block_cipher.sv
// Simon 48/72 block cipher top level: round sequencer, datapath and result register.
// Each accepted item runs its rounds one round per cycle; the last round waits until the result register is free.
// A new item is accepted only in the idle state; the single round unit and the one read
// port of the round key memory let one item run at a time.
// After reset, and after every key write, the key schedule refills the round key
// memory; no item is accepted while it is busy.
module simon48_72_block_cipher import smn_pkg::*; #(
  parameter int unsigned NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [WORD_W-1:0]    first_word_i,
  input  logic [WORD_W-1:0]    second_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_W-1:0]    result_first_word_o,
  output logic [WORD_W-1:0]    result_second_word_o
);

  localparam int unsigned ADDR_W = $clog2(NUM_ROUNDS);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_ROUNDS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] rnd_q;
  logic              dec_q;
  logic [WORD_W-1:0] x_q, y_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] res_first_q, res_second_q;

  logic              ks_busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rkey;
  logic              in_acc, out_free, last_rnd, adv;
  logic [WORD_W-1:0] x_next;

  smn_key_sched #(
    .NUM_ROUNDS (NUM_ROUNDS),
    .ADDR_W     (ADDR_W)
  ) u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rkey),
    .busy_o     (ks_busy)
  );

  always_comb begin
    in_stall_o = (state_q != ST_IDLE) || ks_busy;
    in_acc     = in_valid_i && !in_stall_o;
    out_free   = !out_valid_q || !out_stall_i;
    last_rnd   = (rnd_q == LAST);
    // the last round waits until the result register is free
    adv        = (state_q == ST_RUN) && (!last_rnd || out_free);
    x_next     = round_f(x_q) ^ y_q ^ rkey;
    rd_en      = 1'b0;
    rd_addr    = '0;
    if (in_acc) begin
      rd_en   = 1'b1;
      rd_addr = (command_i == CMD_DECRYPT) ? LAST : '0;
    end else if (adv && !last_rnd) begin
      rd_en   = 1'b1;
      rd_addr = dec_q ? (LAST - rnd_q - 1'b1) : (rnd_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !(adv && last_rnd)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_RUN;
            rnd_q   <= '0;
          end
        end
        ST_RUN: begin
          if (adv) begin
            rnd_q <= rnd_q + 1'b1;
            if (last_rnd) begin
              state_q     <= ST_IDLE;
              out_valid_q <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dec_q <= command_i;
      x_q   <= (command_i == CMD_DECRYPT) ? first_word_i : second_word_i;
      y_q   <= (command_i == CMD_DECRYPT) ? second_word_i : first_word_i;
    end else if (adv) begin
      x_q <= x_next;
      y_q <= x_q;
      if (last_rnd) begin
        res_first_q  <= dec_q ? x_next : x_q;
        res_second_q <= dec_q ? x_q : x_next;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_first_word_o  = res_first_q;
  assign result_second_word_o = res_second_q;

  a_no_accept_while_expanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !ks_busy)
    else $error("item accepted while round keys are being expanded");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_RUN && rnd_q == '0)
    else $error("accepted item did not start the round sequence");

  a_finish_sets_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && last_rnd && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("last round did not post a result");

  a_result_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_first_q)
                                   && $stable(res_second_q))
    else $error("waiting result was overwritten");

endmodule

### sim/tb.sv
// Testbench for the Simon 48/72 cipher engine: directed and random blocks checked in-line.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smn_pkg::*;

  localparam int unsigned NUM_ROUNDS = NUM_ROUNDS_DEF;
  localparam logic [KEY_IDX_W-1:0] KEY_NONE = 2'd3;  // unmapped index, write is dropped
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int RANDOM_PHASES    = 8;
  localparam int BLOCKS_PER_PHASE = 222;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } block_t;

  typedef struct packed {
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } cipher_out_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [KEY_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 command_i;
  logic [WORD_W-1:0]    first_word_i;
  logic [WORD_W-1:0]    second_word_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [WORD_W-1:0]    result_first_word_o;
  logic [WORD_W-1:0]    result_second_word_o;

  simon48_72_block_cipher uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .first_word_i        (first_word_i),
    .second_word_i       (second_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_first_word_o (result_first_word_o),
    .result_second_word_o(result_second_word_o)
  );

  // cipher state mirrored in the testbench
  logic [WORD_W-1:0] key_words  [KEY_WORDS];
  logic [WORD_W-1:0] round_keys [NUM_ROUNDS];

  block_t      blocks_to_send [$];
  cipher_out_t expected_blocks [$];
  block_t      next_block;

  int  blocks_queued   = 0;
  int  blocks_taken    = 0;
  int  results_checked = 0;
  int  n_encrypt       = 0;
  int  n_decrypt       = 0;
  int  key_settings    = 0;
  int  errors          = 0;
  int  quiet_cycles    = 0;
  int  send_gap        = 0;
  int  send_calm       = 0;
  int  stall_gap       = 0;
  int  stall_calm      = 0;
  bit  in_took         = 0;
  bit  idling_on       = 1;

  // one Feistel mixing step: (x <<< 1 & x <<< 8) ^ x <<< 2
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ({x[22:0], x[23]} & {x[15:0], x[23:16]}) ^ {x[21:0], x[23:22]};
  endfunction

  function automatic void schedule_round_keys();
    logic [WORD_W-1:0] w [NUM_ROUNDS];
    logic [WORD_W-1:0] t;
    for (int i = 0; i < KEY_WORDS; i++) w[i] = key_words[i];
    for (int i = 0; i + KEY_WORDS < NUM_ROUNDS; i++) begin
      t = {w[i+2][2:0], w[i+2][23:3]};
      t = t ^ {t[0], t[23:1]};
      w[i+3] = w[i] ^ t ^ KEY_CONST ^ {{(WORD_W-1){1'b0}}, Z0_SEQ[i % ZSEQ_LEN]};
    end
    round_keys = w;
  endfunction

  function automatic cipher_out_t simon_crypt(input block_t b);
    logic [WORD_W-1:0] x, y, nx, k;
    cipher_out_t       r;
    if (b.cmd == CMD_DECRYPT) begin
      x = b.first;
      y = b.second;
    end else begin
      y = b.first;
      x = b.second;
    end
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      k  = (b.cmd == CMD_DECRYPT) ? round_keys[NUM_ROUNDS-1-i] : round_keys[i];
      nx = mix(x) ^ y ^ k;
      y  = x;
      x  = nx;
    end
    if (b.cmd == CMD_DECRYPT) r = '{first: x, second: y};
    else r = '{first: y, second: x};
    return r;
  endfunction

  task automatic queue_block(input logic cmd, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b);
    blocks_to_send.push_back('{cmd: cmd, first: a, second: b});
    blocks_queued++;
  endtask

  // encrypt a block, then decrypt the ciphertext back
  task automatic queue_round_trip(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    cipher_out_t c;
    c = simon_crypt('{cmd: CMD_ENCRYPT, first: a, second: b});
    queue_block(CMD_ENCRYPT, a, b);
    queue_block(CMD_DECRYPT, c.first, c.second);
  endtask

  task automatic key_write(input logic [KEY_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < KEY_WORDS) begin
      key_words[idx] = data;
      schedule_round_keys();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                         input logic [WORD_W-1:0] k2);
    key_write(KEY_LOW, k0);
    key_write(KEY_MID, k1);
    key_write(KEY_HIGH, k2);
    key_settings++;
  endtask

  // counters move at the rising edge only, so checking at the falling edge is race free
  task automatic wait_idle();
    while (blocks_taken != blocks_queued || expected_blocks.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W-1);
      default: return WORD_W'($urandom);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input side: random gap bursts, with calm stretches in between
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_took)) begin
      if (send_gap == 0 && idling_on && send_calm == 0 && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 18);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (blocks_to_send.size() != 0) begin
        next_block = blocks_to_send.pop_front();
        command_i     <= next_block.cmd;
        first_word_i  <= next_block.first;
        second_word_i <= next_block.second;
        in_valid_i    <= 1'b1;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(10, 60);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stall bursts
  always @(negedge clk_i) begin
    if (stall_gap == 0 && idling_on) begin
      if (stall_calm > 0) stall_calm--;
      else if ($urandom_range(0, 7) == 0) stall_gap = $urandom_range(1, 18);
      else if ($urandom_range(0, 31) == 0) stall_calm = $urandom_range(20, 150);
    end
    if (stall_gap > 0) begin
      stall_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cipher_out_t exp_out;
    in_took = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        in_took = 1'b1;
        blocks_taken++;
        if (command_i == CMD_DECRYPT) n_decrypt++;
        else n_encrypt++;
        expected_blocks.push_back(simon_crypt('{cmd: command_i, first: first_word_i,
                                                second: second_word_i}));
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: result with no item pending: %06h %06h", $time,
                   result_first_word_o, result_second_word_o);
          errors++;
        end else begin
          exp_out = expected_blocks.pop_front();
          results_checked++;
          if (result_first_word_o !== exp_out.first) begin
            $display("%0t: result_first_word mismatch: expected %06h, actual %06h", $time,
                     exp_out.first, result_first_word_o);
            errors++;
          end
          if (result_second_word_o !== exp_out.second) begin
            $display("%0t: result_second_word mismatch: expected %06h, actual %06h", $time,
                     exp_out.second, result_second_word_o);
            errors++;
          end
        end
      end
      if (in_took || (out_valid_o === 1'b1 && !out_stall_i) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
             QUIET_LIMIT, expected_blocks.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int       n;
    int       pattern;
    logic [KEY_IDX_W-1:0] idx;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = KEY_LOW;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_ENCRYPT;
    first_word_i  = '0;
    second_word_i = '0;
    out_stall_i   = 1'b0;
    rst_ni        = 1'b0;
    for (int i = 0; i < KEY_WORDS; i++) key_words[i] = '0;
    schedule_round_keys();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // all-zero key from reset: field extremes, both commands
    key_settings++;
    queue_block(CMD_ENCRYPT, 24'h000000, 24'h000000);
    queue_block(CMD_DECRYPT, 24'h000000, 24'h000000);
    queue_block(CMD_ENCRYPT, 24'hFFFFFF, 24'hFFFFFF);
    queue_block(CMD_DECRYPT, 24'hFFFFFF, 24'hFFFFFF);
    queue_block(CMD_ENCRYPT, 24'hFFFFFF, 24'h000000);
    queue_block(CMD_DECRYPT, 24'h000000, 24'hFFFFFF);
    queue_block(CMD_ENCRYPT, 24'hAAAAAA, 24'h555555);
    queue_block(CMD_DECRYPT, 24'h555555, 24'hAAAAAA);
    queue_block(CMD_ENCRYPT, 24'h800000, 24'h000001);
    queue_block(CMD_DECRYPT, 24'h000001, 24'h800000);
    queue_round_trip(24'h123456, 24'hABCDEF);
    wait_idle();

    set_key('1, '1, '1);
    queue_block(CMD_ENCRYPT, 24'h000000, 24'h000000);
    queue_round_trip(24'hFFFFFF, 24'h000000);
    wait_idle();

    // published 48/72 test vector, both directions
    set_key(24'h0A0908, 24'h121110, 24'h1A1918);
    queue_block(CMD_ENCRYPT, 24'h696874, 24'h6D2073);
    queue_block(CMD_DECRYPT, 24'hDAE5AC, 24'h292CAC);
    wait_idle();

    // write to the unmapped index must leave the schedule alone
    key_write(KEY_NONE, 24'h5A5A5A);
    set_key(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    key_write(KEY_NONE, WORD_W'($urandom));
    queue_round_trip(24'h0F0F0F, 24'hF0F0F0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) idling_on = 1'b0;
      pattern = $urandom_range(0, 3);
      case (pattern)
        0: set_key(pick_word(), pick_word(), pick_word());
        1: begin
          key_write(KEY_HIGH, pick_word());
          key_write(KEY_MID, pick_word());
          key_write(KEY_LOW, pick_word());
          key_settings++;
        end
        2: begin
          idx = KEY_IDX_W'($urandom_range(0, KEY_WORDS - 1));
          key_write(idx, pick_word());
          key_settings++;
        end
        default: begin
          key_write(KEY_NONE, WORD_W'($urandom));
          set_key(WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
        end
      endcase
      n = 0;
      while (n < BLOCKS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          6, 7: begin
            queue_round_trip(WORD_W'($urandom), WORD_W'($urandom));
            n += 2;
          end
          8: begin
            queue_block(1'($urandom), pick_word(), pick_word());
            n++;
          end
          default: begin
            queue_block(1'($urandom), WORD_W'($urandom), WORD_W'($urandom));
            n++;
          end
        endcase
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Ran %0d encryptions and %0d decryptions under %0d key settings;",
             n_encrypt, n_decrypt, key_settings);
    $display("%0d results compared, %0d mismatches.", results_checked, errors);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/smn_pkg.sv
src/smn_key_sched.sv
src/simon48_72_block_cipher.sv
sim/tb.sv
